### rtl/core/vpci_pkg.sv
// Shared types and constants for the virtio PCI register block.
`default_nettype none
package vpci_pkg;
   localparam int MAX_QUEUES    = 8;
   localparam int DEVCFG_BYTES  = 256;
   localparam int NOTIFY_STRIDE = 4;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_IRQ   = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_UNSUP    = 3'd1;
   localparam logic [2:0] ST_BADSTATE = 3'd2;
   localparam logic [2:0] ST_SIZE     = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;
   localparam logic [2:0] ST_ALIGN    = 3'd5;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_READY  = 3'd1;
   localparam logic [2:0] EV_QCFG   = 3'd2;
   localparam logic [2:0] EV_NOTIFY = 3'd3;
   localparam logic [2:0] EV_DEVCFG = 3'd4;

   localparam logic [1:0] CSR_NUM_QUEUES = 2'd0;
   localparam logic [1:0] CSR_DEV_FEAT   = 2'd1;
   localparam logic [1:0] CSR_DEVCFG_SZ  = 2'd2;

   localparam logic [15:0] ISR_OFF     = 16'h0038;
   localparam logic [15:0] DEVCFG_BASE = 16'h003c;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  status_code;
      logic [2:0]  event_kind;
      logic [2:0]  event_queue;
      logic [31:0] event_data;
      logic        irq_pending;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_OUT  = 3'b100
   } state_type;
endpackage
`default_nettype wire

### rtl/core/vpci_devcfg_mem.sv
// Device-config byte store: four byte lanes, one aligned word per address.
`default_nettype none
module vpci_devcfg_mem
   import vpci_pkg::*;
#(
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [3:0]    wr_mask,
   input  wire logic [31:0]   wr_data
);
   logic [31:0] mem [2**AW];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         for (int i = 0; i < 4; i++) begin
            if (wr_mask[i]) mem[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
         end
      end
   end
   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/core/vpci_queue_mem.sv
// Per-queue store: size plus six address words, eight words per queue.
`default_nettype none
module vpci_queue_mem
   import vpci_pkg::*;
#(
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data
);
   logic [31:0] mem [2**AW];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end
   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/core/virtio_pci_register_block_core.sv
// Top level of the virtio PCI register block.
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata
//  csr     | in  | csr_wr_en          | csr_index, csr_wdata
// An item goes through accept while the queue and devcfg RAMs are read, execute
// and write back, then the output transfer.
// Reset is synchronous; after it both RAMs take a clearing pass over every address,
// in which req_tready is low. Response waits in a register while rsp_tready is low,
// and req_tready stays low until it is taken.
`default_nettype none
module virtio_pci_register_block_core
   import vpci_pkg::*;
#(
   parameter int CONFIG_BAR    = 0,
   parameter int NOTIFY_BAR    = 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[1:0], bar_index[4:2], access_offset[20:5], access_bytes[24:21],
   // wdata[56:25], irq_bits[64:57]
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[31:0], status_code[34:32], event_kind[37:35], event_queue[40:38],
   // event_data[72:41], irq_pending[73]
   output logic [79:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam int QAW  = $clog2(MAX_QUEUES * 8);
   localparam int DAW  = (DEVCFG_BYTES > 4) ? $clog2(DEVCFG_BYTES / 4) : 1;
   localparam int CLRW = (QAW > DAW) ? QAW : DAW;

   logic [3:0]  num_queues_ff;
   logic [31:0] dev_feat_ff;
   logic [8:0]  devcfg_size_ff;
   logic [31:0] dev_sel_ff, drv_sel_ff, drv_feat_ff;
   logic [7:0]  dev_status_ff, isr_ff;
   logic [2:0]  qsel_ff;
   state_type   state_ff;
   logic [CLRW:0] clr_ff;
   logic [71:0] req_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        q_we, d_we;
   logic [QAW-1:0] q_raddr, q_waddr;
   logic [DAW-1:0] d_raddr, d_waddr;
   logic [31:0] q_rdata, d_rdata, q_wdata, d_wdata;
   logic [3:0]  d_mask;

   logic        clearing;
   assign clearing = !clr_ff[CLRW];

   // request fields: live input in IDLE (address to RAMs), latched in EXEC
   logic [71:0] rq;
   assign rq = (state_ff == S_IDLE) ? req_tdata : req_ff;
   logic [1:0]  op;
   logic [2:0]  bar;
   logic [15:0] off;
   logic [3:0]  sz;
   logic [31:0] wd;
   logic [7:0]  irq;
   assign op  = rq[1:0];
   assign bar = rq[4:2];
   assign off = rq[20:5];
   assign sz  = rq[24:21];
   assign wd  = rq[56:25];
   assign irq = rq[64:57];

   logic [15:0] ca;
   logic [3:0]  nq;
   logic [8:0]  used;
   assign ca   = off - DEVCFG_BASE;
   assign nq   = (32'(num_queues_ff) > MAX_QUEUES) ? 4'(MAX_QUEUES) : num_queues_ff;
   assign used = (32'(devcfg_size_ff) > DEVCFG_BYTES) ? 9'(DEVCFG_BYTES) : devcfg_size_ff;

   // queue word slot: 0 size, 2..7 address words
   logic [2:0] qslot;
   assign qslot = (off == 16'h0018) ? 3'd0 : 3'(((off - 16'h0020) >> 2) + 16'd2);
   logic [QAW+2:0] qfull;
   assign qfull   = {(QAW)'(qsel_ff), qslot};
   assign q_raddr = clearing ? clr_ff[QAW-1:0] : qfull[QAW-1:0];
   assign d_raddr = clearing ? clr_ff[DAW-1:0] : DAW'(ca >> 2);

   vpci_queue_mem #(.AW(QAW)) u_qmem (
      .clock(clock), .rd_addr(q_raddr), .rd_data(q_rdata),
      .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata));
   vpci_devcfg_mem #(.AW(DAW)) u_dmem (
      .clock(clock), .rd_addr(d_raddr), .rd_data(d_rdata),
      .wr_en(d_we), .wr_addr(d_waddr), .wr_mask(d_mask), .wr_data(d_wdata));

   logic        qok;
   logic        in_cfg;
   logic [15:0] base;
   logic [31:0] cfgword;
   logic [31:0] dev_sel_in, drv_sel_in, drv_feat_in;
   logic [7:0]  dev_status_in, isr_in;
   logic [2:0]  qsel_in;
   logic        qw;
   logic [15:0] nidx;
   logic [31:0] cfgrd;
   assign qok    = {1'b0, qsel_ff} < nq;
   assign in_cfg = off >= DEVCFG_BASE && 17'(off) < 17'(DEVCFG_BASE) + 17'(used);
   assign nidx   = 16'(32'(off) / NOTIFY_STRIDE);

   always_comb begin
      base = 16'h0;
      case (sz)
         4'd2:    base = {ca[15:1], 1'b0};
         4'd4:    base = {ca[15:2], 2'b0};
         default: base = ca;
      endcase
      // bytes past the store read zero
      cfgword = d_rdata;
      for (int i = 0; i < 4; i++) begin
         if (32'({ca[15:2], 2'b0}) + i >= DEVCFG_BYTES) cfgword[8*i +: 8] = 8'h0;
      end
      cfgrd = cfgword >> (8 * base[1:0]);
      case (sz)
         4'd1:    cfgrd = {24'h0, cfgrd[7:0]};
         4'd2:    cfgrd = {16'h0, cfgrd[15:0]};
         default: ;
      endcase

      dev_sel_in = dev_sel_ff; drv_sel_in = drv_sel_ff; drv_feat_in = drv_feat_ff;
      dev_status_in = dev_status_ff; isr_in = isr_ff; qsel_in = qsel_ff;
      rsp_in = '0;
      rsp_in.status_code = ST_UNSUP;
      q_we = 1'b0; q_waddr = qfull[QAW-1:0]; q_wdata = wd;
      d_we = 1'b0; d_waddr = DAW'(ca >> 2); d_mask = 4'h0; d_wdata = wd;
      qw = off >= 16'h0020 && off < ISR_OFF;

      if (clearing) begin
         q_we = 1'b1; q_waddr = clr_ff[QAW-1:0]; q_wdata = '0;
         d_we = 1'b1; d_waddr = clr_ff[DAW-1:0]; d_mask = 4'hf; d_wdata = '0;
      end else if (state_ff == S_EXEC) begin
         if (op == OP_IRQ) begin
            isr_in = isr_ff | irq;
            rsp_in.status_code = ST_OK;
         end else if (op == OP_READ && 32'(bar) == CONFIG_BAR) begin
            if (off < ISR_OFF) begin
               rsp_in.status_code = ST_OK;
               case (off)
                  16'h0000: rsp_in.read_data = dev_sel_ff;
                  16'h0004: rsp_in.read_data = (dev_sel_ff == 32'd1) ? 32'd1 :
                                               (dev_sel_ff != 0) ? 32'd0 : dev_feat_ff;
                  16'h0008: rsp_in.read_data = drv_sel_ff;
                  16'h000c: rsp_in.read_data = (drv_sel_ff != 0) ? 32'd0 : drv_feat_ff;
                  16'h0010, 16'h0015, 16'h001a, 16'h001c: rsp_in.read_data = 32'd0;
                  16'h0012: rsp_in.read_data = 32'(num_queues_ff);
                  16'h0014: rsp_in.read_data = 32'(dev_status_ff);
                  16'h0016: rsp_in.read_data = 32'(qsel_ff);
                  16'h0018: if (qok) rsp_in.read_data = {16'h0, q_rdata[15:0]};
                            else rsp_in.status_code = ST_BADSTATE;
                  16'h001e: if (qok) rsp_in.read_data = 32'(qsel_ff);
                            else rsp_in.status_code = ST_BADSTATE;
                  default: begin
                     if (qw) begin
                        if (qok) rsp_in.read_data = q_rdata;
                        else rsp_in.status_code = ST_BADSTATE;
                     end else rsp_in.status_code = ST_UNSUP;
                  end
               endcase
            end else if (off == ISR_OFF) begin
               rsp_in.read_data = 32'(isr_ff);
               isr_in = 8'h0;
               rsp_in.status_code = ST_OK;
            end else if (in_cfg && (sz == 4'd1 || sz == 4'd2 || sz == 4'd4)) begin
               rsp_in.read_data = cfgrd;
               rsp_in.status_code = ST_OK;
            end
         end else if (op == OP_WRITE && 32'(bar) == CONFIG_BAR) begin
            if (off < ISR_OFF) begin
               rsp_in.status_code = ST_OK;
               case (off)
                  16'h0000: if (sz != 4'd4) rsp_in.status_code = ST_SIZE;
                            else dev_sel_in = wd;
                  16'h0008: if (sz != 4'd4) rsp_in.status_code = ST_SIZE;
                            else drv_sel_in = wd;
                  16'h000c: if (sz != 4'd4) rsp_in.status_code = ST_SIZE;
                            else if (drv_sel_ff == 0) drv_feat_in = wd;
                  16'h0014: begin
                     if (sz != 4'd1) rsp_in.status_code = ST_SIZE;
                     else begin
                        dev_status_in = wd[7:0];
                        if (wd[2]) begin
                           rsp_in.event_kind = EV_READY;
                           rsp_in.event_data = dev_feat_ff & drv_feat_ff;
                        end
                     end
                  end
                  16'h0016: begin
                     if (sz != 4'd2) rsp_in.status_code = ST_SIZE;
                     else if (wd[15:0] >= 16'(nq)) rsp_in.status_code = ST_RANGE;
                     else qsel_in = wd[2:0];
                  end
                  16'h0018: begin
                     if (sz != 4'd2) rsp_in.status_code = ST_SIZE;
                     else if (!qok) rsp_in.status_code = ST_BADSTATE;
                     else begin q_we = 1'b1; q_wdata = {16'h0, wd[15:0]}; end
                  end
                  16'h001c: begin
                     if (sz != 4'd2) rsp_in.status_code = ST_SIZE;
                     else if (!qok) rsp_in.status_code = ST_BADSTATE;
                     else if (wd[15:0] == 16'h0) rsp_in.status_code = ST_UNSUP;
                     else begin
                        rsp_in.event_kind = EV_QCFG;
                        rsp_in.event_queue = qsel_ff;
                     end
                  end
                  16'h0010, 16'h001a: ;
                  default: begin
                     if (qw) begin
                        if (sz != 4'd4) rsp_in.status_code = ST_SIZE;
                        else if (!qok) rsp_in.status_code = ST_BADSTATE;
                        else q_we = 1'b1;
                     end else rsp_in.status_code = ST_UNSUP;
                  end
               endcase
            end else if (in_cfg && (sz == 4'd1 || sz == 4'd2 || sz == 4'd4)) begin
               d_we = 1'b1;
               d_wdata = wd << (8 * base[1:0]);
               case (sz)
                  4'd1:    d_mask = 4'b0001 << base[1:0];
                  4'd2:    d_mask = 4'b0011 << base[1:0];
                  default: d_mask = 4'b1111;
               endcase
               for (int i = 0; i < 4; i++) begin
                  if (32'({ca[15:2], 2'b0}) + i >= DEVCFG_BYTES) d_mask[i] = 1'b0;
               end
               rsp_in.status_code = ST_OK;
               rsp_in.event_kind = EV_DEVCFG;
               rsp_in.event_data = 32'(ca);
            end
         end else if (op == OP_WRITE && 32'(bar) == NOTIFY_BAR) begin
            if (32'(off) % NOTIFY_STRIDE != 0) rsp_in.status_code = ST_ALIGN;
            else if (nidx >= 16'(nq)) rsp_in.status_code = ST_RANGE;
            else begin
               rsp_in.status_code = ST_OK;
               rsp_in.event_kind = EV_NOTIFY;
               rsp_in.event_queue = nidx[2:0];
            end
         end
         rsp_in.irq_pending = isr_in != 8'h0;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !clearing;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {6'h0, rsp_ff.irq_pending, rsp_ff.event_data, rsp_ff.event_queue,
                        rsp_ff.event_kind, rsp_ff.status_code, rsp_ff.read_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         num_queues_ff <= 4'd1; dev_feat_ff <= '0; devcfg_size_ff <= '0;
         dev_sel_ff <= '0; drv_sel_ff <= '0; drv_feat_ff <= '0;
         dev_status_ff <= '0; isr_ff <= '0; qsel_ff <= '0;
         state_ff <= S_IDLE; clr_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_QUEUES: num_queues_ff  <= csr_wdata[3:0];
               CSR_DEV_FEAT:   dev_feat_ff    <= csr_wdata;
               CSR_DEVCFG_SZ:  devcfg_size_ff <= csr_wdata[8:0];
               default: ;
            endcase
         end
         if (clearing) clr_ff <= clr_ff + 1'b1;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) state_ff <= S_EXEC;
            S_EXEC: begin
               state_ff <= S_OUT;
               dev_sel_ff <= dev_sel_in; drv_sel_ff <= drv_sel_in;
               drv_feat_ff <= drv_feat_in; dev_status_ff <= dev_status_in;
               isr_ff <= isr_in; qsel_ff <= qsel_in;
            end
            S_OUT:  if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) req_ff <= req_tdata;
      if (state_ff == S_EXEC) rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire
